// File: src/ftlb_pkg.sv
// ----------------------------------------------------------------------------
// ftlb_pkg
// Shared sizes, status codes, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ftlb_pkg;

	localparam int TLB_ENTRIES = 16;     // 1 .. 16
	localparam int RAM_PAGES   = 64;     // 1 .. 64
	localparam int VIRT_PAGES  = 65536;  // 1 .. 2**20

	localparam int VPN_W  = 20;
	localparam int SLOT_W = 4;
	localparam int PAGE_W = 6;
	localparam int STAT_W = 3;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_MISS       = 3'd1,
		ST_RANGE      = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_RAM_FULL   = 3'd4
	} ftlb_status_t;

	typedef enum logic {
		REQ_TRANSLATE = 1'b0,
		REQ_PLACE     = 1'b1
	} ftlb_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SLOT_SCAN,
		S_PAGE_SCAN,
		S_MATCH_SCAN
	} ftlb_state_t;

	typedef struct packed {
		logic         load;      // capture request, rewind both scan counters
		logic         slot_inc;
		logic         page_inc;
		logic         commit;    // fill slot, mark page used
		logic         respond;
		ftlb_status_t resp_code;
	} ftlb_cmd_t;

	typedef struct packed {
		logic is_place;
		logic out_of_range;
		logic slot_free;
		logic slot_last;
		logic page_free;
		logic page_last;
		logic hit;
	} ftlb_stat_t;

endpackage

`default_nettype wire

// File: src/fully_assoc_tlb_with_page_alloc.sv
// Sequence: after start is taken, done follows the dispatch step and the scan;
//   a range fail ends at dispatch, translate walks slots up to the first hit or last
//   slot, place walks slots and then pages (a full table ends after the slot walk).
// Throughput: one transaction at a time; start is taken again the cycle busy
//   drops, which is the cycle the result strobe is shown. done cannot be stalled.
// Reset: arst_n clears every slot, frees every page, and idles the sequencer.
// ----------------------------------------------------------------------------
// fully_assoc_tlb_with_page_alloc
// Fully associative translation table with physical page allocation.
// ----------------------------------------------------------------------------
`default_nettype none

module fully_assoc_tlb_with_page_alloc (
	input  wire                           clk,
	input  wire                           arst_n,
	// request transaction: taken when start is high and busy is low
	input  wire                           start,
	output logic                          busy,
	input  wire                           req_type,
	input  wire  [ftlb_pkg::VPN_W-1:0]    vpn,
	// result transaction: valid for the single cycle done is high
	output logic                          done,
	output logic [ftlb_pkg::STAT_W-1:0]   status,
	output logic [ftlb_pkg::SLOT_W-1:0]   slot,
	output logic [ftlb_pkg::PAGE_W-1:0]   phys_page
);
	import ftlb_pkg::*;

	// Controller drives the datapath purely through cmd and watches st.
	//  place:     dispatch -> walk slots to the first free one
	//             -> walk pages to the first free one -> commit + respond
	//             (table full / RAM full end the walk with nothing claimed)
	//  translate: dispatch (range check) -> walk slots for the first hit
	ftlb_cmd_t  cmd;
	ftlb_stat_t st;

	ftlb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	// Request is captured only on cmd.load, i.e. on the accepting edge.
	ftlb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req_type  (req_type),
		.vpn       (vpn),
		.done      (done),
		.status    (status),
		.slot      (slot),
		.phys_page (phys_page)
	);

endmodule

`default_nettype wire

// File: src/ftlb_ctrl.sv
// ----------------------------------------------------------------------------
// ftlb_ctrl
// Request sequencer: dispatches the request and steps the slot and page
// scans of the datapath one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ftlb_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  ftlb_pkg::ftlb_stat_t st,
	output ftlb_pkg::ftlb_cmd_t  cmd
);
	import ftlb_pkg::*;

	ftlb_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (st.is_place)          state_nxt = S_SLOT_SCAN;
				else if (st.out_of_range) state_nxt = S_IDLE;
				else                      state_nxt = S_MATCH_SCAN;
			end
			S_SLOT_SCAN: begin
				if (st.slot_free)      state_nxt = S_PAGE_SCAN;
				else if (st.slot_last) state_nxt = S_IDLE;
			end
			S_PAGE_SCAN: begin
				if (st.page_free || st.page_last) state_nxt = S_IDLE;
			end
			S_MATCH_SCAN: begin
				if (st.hit || st.slot_last) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.resp_code = ST_OK;
		busy          = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_DISPATCH: begin
				if (!st.is_place && st.out_of_range) begin
					cmd.respond   = 1'b1;
					cmd.resp_code = ST_RANGE;
				end
			end
			S_SLOT_SCAN: begin
				if (!st.slot_free) begin
					if (st.slot_last) begin
						cmd.respond   = 1'b1;
						cmd.resp_code = ST_TABLE_FULL;
					end else begin
						cmd.slot_inc = 1'b1;
					end
				end
			end
			S_PAGE_SCAN: begin
				if (st.page_free) begin
					cmd.commit    = 1'b1;
					cmd.respond   = 1'b1;
					cmd.resp_code = ST_OK;
				end else if (st.page_last) begin
					cmd.respond   = 1'b1;
					cmd.resp_code = ST_RAM_FULL;
				end else begin
					cmd.page_inc = 1'b1;
				end
			end
			S_MATCH_SCAN: begin
				if (st.hit) begin
					cmd.respond   = 1'b1;
					cmd.resp_code = ST_OK;
				end else if (st.slot_last) begin
					cmd.respond   = 1'b1;
					cmd.resp_code = ST_MISS;
				end else begin
					cmd.slot_inc = 1'b1;
				end
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/ftlb_dp.sv
// ----------------------------------------------------------------------------
// ftlb_dp
// Translation table storage, page free marks, scan counters and the
// registered response.
// ----------------------------------------------------------------------------
`default_nettype none

module ftlb_dp (
	input  wire                                clk,
	input  wire                                arst_n,
	input  ftlb_pkg::ftlb_cmd_t                cmd,
	output ftlb_pkg::ftlb_stat_t               st,
	input  wire                                req_type,
	input  wire  [ftlb_pkg::VPN_W-1:0]         vpn,
	output logic                               done,
	output logic [ftlb_pkg::STAT_W-1:0]        status,
	output logic [ftlb_pkg::SLOT_W-1:0]        slot,
	output logic [ftlb_pkg::PAGE_W-1:0]        phys_page
);
	import ftlb_pkg::*;

	logic [TLB_ENTRIES-1:0] slot_valid_q;
	logic [VPN_W-1:0]       slot_vpn_q  [TLB_ENTRIES];
	logic [PAGE_W-1:0]      slot_phys_q [TLB_ENTRIES];
	logic [RAM_PAGES-1:0]   page_free_q;

	logic              place_q;
	logic [VPN_W-1:0]  vpn_q;
	logic [SLOT_W-1:0] slot_idx_q;
	logic [PAGE_W-1:0] page_idx_q;

	logic              done_q;
	ftlb_status_t      status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PAGE_W-1:0] phys_q;

	// status toward the controller
	always_comb begin
		st.is_place     = place_q;
		st.out_of_range = ({1'b0, vpn_q} >= (VPN_W+1)'(VIRT_PAGES));
		st.slot_free    = !slot_valid_q[slot_idx_q];
		st.slot_last    = (slot_idx_q == SLOT_W'(TLB_ENTRIES-1));
		st.page_free    = page_free_q[page_idx_q];
		st.page_last    = (page_idx_q == PAGE_W'(RAM_PAGES-1));
		st.hit          = slot_valid_q[slot_idx_q] && (slot_vpn_q[slot_idx_q] == vpn_q);
	end

	// request capture and scan counters
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			place_q    <= (req_type == REQ_PLACE);
			vpn_q      <= vpn;
			slot_idx_q <= '0;
			page_idx_q <= '0;
		end else begin
			if (cmd.slot_inc) slot_idx_q <= slot_idx_q + 1'b1;
			if (cmd.page_inc) page_idx_q <= page_idx_q + 1'b1;
		end
	end

	// occupancy marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			page_free_q  <= '1;
		end else if (cmd.commit) begin
			slot_valid_q[slot_idx_q] <= 1'b1;
			page_free_q[page_idx_q]  <= 1'b0;
		end
	end

	// entry contents
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			slot_vpn_q[slot_idx_q]  <= vpn_q;
			slot_phys_q[slot_idx_q] <= page_idx_q;
		end
	end

	// response register, one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			status_q <= cmd.resp_code;
			slot_q   <= '0;
			phys_q   <= '0;
			if (cmd.resp_code == ST_OK) begin
				if (place_q) begin
					slot_q <= slot_idx_q;
					phys_q <= page_idx_q;
				end else begin
					phys_q <= slot_phys_q[slot_idx_q];
				end
			end
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign phys_page = phys_q;

endmodule

`default_nettype wire
